// ===== hdl/pat_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pat_pkg
// Shared constants, types and helpers for the packet ack tracker.
// ---------------------------------------------------------------------------
package pat_pkg;

	// Sequence numbers and history ring
	localparam int SEQ_W       = 8;
	localparam int RING_DEPTH  = 32;
	localparam int RING_AW     = $clog2(RING_DEPTH);
	localparam int SCAN_CNT_W  = $clog2(RING_DEPTH + 1);
	localparam int ACK_WINDOW  = 32;
	localparam int ACK_BITS_W  = 31;
	localparam int HALF_RANGE  = 128;

	// Item modes
	localparam logic MODE_SEND = 1'b0;
	localparam logic MODE_RECV = 1'b1;

	typedef logic [SEQ_W-1:0]      seq_t;
	typedef logic [RING_AW-1:0]    ring_addr_t;
	typedef logic [ACK_BITS_W-1:0] ack_bits_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} ctrl_state_t;

	// Request to the history ring
	typedef struct packed {
		logic       re;
		ring_addr_t raddr;
		logic       we;
		ring_addr_t waddr;
		seq_t       wdata;
	} ring_req_t;

	// One result item
	typedef struct packed {
		seq_t      tx_sequence;
		seq_t      ack_sequence;
		ack_bits_t ack_bits;
		logic      accepted;
	} result_t;

	// Wraparound newer test: a sequence exactly half range ahead counts as newer
	// only when it is numerically larger.
	function automatic logic seq_newer(input seq_t nxt, input seq_t cur);
		seq_t diff;
		logic res;
		diff = nxt - cur;
		if (nxt > cur) begin
			res = ({1'b0, diff} <= (SEQ_W+1)'(HALF_RANGE));
		end else if (nxt < cur) begin
			res = ({1'b0, diff} < (SEQ_W+1)'(HALF_RANGE));
		end else begin
			res = 1'b0;
		end
		return res;
	endfunction

	// Ack bit set by one ring entry: bit d-1 for distance d in 1..ACK_WINDOW-1
	function automatic ack_bits_t ack_mask(input seq_t remote, input seq_t entry);
		seq_t      delta;
		ack_bits_t m;
		delta = remote - entry;
		m = '0;
		for (int k = 0; k < ACK_BITS_W; k++) begin
			if ((k + 1 < ACK_WINDOW) && (delta == SEQ_W'(k + 1))) begin
				m[k] = 1'b1;
			end
		end
		return m;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/pat_ring.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pat_ring
// History ring: one write and one read port, registered read data.
// Per-entry valid flops make unwritten entries read as zero after reset.
// ---------------------------------------------------------------------------
module pat_ring (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pat_pkg::ring_req_t req,
	output pat_pkg::seq_t           rd_data
);
	import pat_pkg::*;

	seq_t                  mem [RING_DEPTH];
	seq_t                  rd_data_q;
	logic [RING_DEPTH-1:0] vld_q;
	logic                  rd_vld_q;

	// Storage array, no reset
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_data_q <= mem[req.raddr];
		end
	end

	// Entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.we) begin
				vld_q[req.waddr] <= 1'b1;
			end
			if (req.re) begin
				rd_vld_q <= vld_q[req.raddr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule
`default_nettype wire

// ===== hdl/pat_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pat_ctrl
// Sequencer: handles receive items without a ring scan, scans the ring for send
// items and holds the finished result until the output stage takes it.
// ---------------------------------------------------------------------------
module pat_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               mode,
	input  wire pat_pkg::seq_t      rx_sequence,
	output pat_pkg::ring_req_t      req,
	input  wire pat_pkg::seq_t      rd_data,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output pat_pkg::result_t        res
);
	import pat_pkg::*;

	ctrl_state_t            state_q, state_d;
	seq_t                   local_seq_q;
	seq_t                   remote_seq_q;
	ring_addr_t             wptr_q;
	logic [SCAN_CNT_W-1:0]  idx_q;
	ack_bits_t              bits_q;
	logic                   mode_q;
	logic                   acc_q;

	logic                   take;
	logic                   newer;
	logic                   scan_last;

	assign take      = in_valid && in_ready;
	assign newer     = seq_newer(rx_sequence, remote_seq_q);
	assign scan_last = (idx_q == SCAN_CNT_W'(RING_DEPTH));

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, ring requests and handshake
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		req       = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (mode == MODE_SEND) begin
						req.re    = 1'b1;
						req.raddr = '0;
						state_d   = ST_SCAN;
					end else begin
						req.we    = newer;
						req.waddr = wptr_q;
						req.wdata = rx_sequence;
						state_d   = ST_DONE;
					end
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_DONE;
				end else begin
					req.re    = 1'b1;
					req.raddr = idx_q[RING_AW-1:0];
				end
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequence state and scan counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_seq_q  <= '0;
			remote_seq_q <= '0;
			wptr_q       <= '0;
			idx_q        <= '0;
			mode_q       <= MODE_SEND;
			acc_q        <= 1'b0;
		end else begin
			if (take) begin
				mode_q <= mode;
				idx_q  <= SCAN_CNT_W'(1);
				acc_q  <= (mode == MODE_RECV) && newer;
				if ((mode == MODE_RECV) && newer) begin
					remote_seq_q <= rx_sequence;
					if (wptr_q == RING_AW'(RING_DEPTH - 1)) begin
						wptr_q <= '0;
					end else begin
						wptr_q <= wptr_q + 1'b1;
					end
				end
			end else if ((state_q == ST_SCAN) && !scan_last) begin
				idx_q <= idx_q + 1'b1;
			end
			// local sequence advances once the header has left
			if ((state_q == ST_DONE) && res_ready && (mode_q == MODE_SEND)) begin
				local_seq_q <= local_seq_q + 1'b1;
			end
		end
	end

	// Ack bit accumulation, one ring entry per cycle
	always_ff @(posedge clk) begin
		if (take) begin
			bits_q <= '0;
		end else if (state_q == ST_SCAN) begin
			bits_q <= bits_q | ack_mask(remote_seq_q, rd_data);
		end
	end

	// Result fields; unused fields of each mode are zero
	always_comb begin
		res = '0;
		if (mode_q == MODE_SEND) begin
			res.tx_sequence  = local_seq_q;
			res.ack_sequence = remote_seq_q;
			res.ack_bits     = bits_q;
		end else begin
			res.accepted = acc_q;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/packet_ack_tracker_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// packet_ack_tracker_core
// Sequence number and ack bitfield tracker with a 32-entry history ring.
// ---------------------------------------------------------------------------
//  Channel | Handshake           | Payload
//  --------+---------------------+---------------------------------------------
//  in      | in_valid/in_ready   | mode, rx_sequence
//  out     | out_valid/out_ready | tx_sequence, ack_sequence, ack_bits, accepted
//
//  A receive item does the compare and ring write, then the result hand-off.
//  A send item scans the ring through its single read port, one entry per
//  cycle, before its result hand-off.
//  One item is in work at a time; the output register lets a new item be taken
//  while the previous result waits on out_ready.
//  Reset clears the sequences, write pointer and ring valid bits at once.
// ---------------------------------------------------------------------------
module packet_ack_tracker_core (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  mode,
	input  wire pat_pkg::seq_t         rx_sequence,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output pat_pkg::seq_t              tx_sequence,
	output pat_pkg::seq_t              ack_sequence,
	output pat_pkg::ack_bits_t         ack_bits,
	output logic                       accepted
);
	import pat_pkg::*;

	ring_req_t req;
	seq_t      rd_data;
	logic      res_valid;
	logic      res_ready;
	result_t   res;
	logic      out_valid_q;
	result_t   out_q;

	pat_ring u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (rd_data)
	);

	pat_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.rx_sequence (rx_sequence),
		.req         (req),
		.rd_data     (rd_data),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	// Output register: free when empty or being drained
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign tx_sequence  = out_q.tx_sequence;
	assign ack_sequence = out_q.ack_sequence;
	assign ack_bits     = out_q.ack_bits;
	assign accepted     = out_q.accepted;

endmodule
`default_nettype wire
